FILE: rtl/core/simc_pkg.sv
// Package for the sorted interval merge / complement block.
// Holds widths, configuration register indexes and the result record type.
// No dependencies.
package simc_pkg;

  // Time values are signed nanosecond counts
  localparam int unsigned TimeW = 64;

  // Result queue depth; an item may add two entries
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgOutputMode   = 2'd0,
    CfgEarliestTime = 2'd1,
    CfgLatestTime   = 2'd2
  } cfg_idx_e;

  // Output mode codes
  typedef enum logic {
    ModeMerge      = 1'b0,
    ModeComplement = 1'b1
  } out_mode_e;

  // One result record as held in the queue
  typedef struct packed {
    logic                    last;
    logic signed [TimeW-1:0] stop;
    logic signed [TimeW-1:0] start;
  } result_t;

endpackage

FILE: rtl/core/sorted_interval_merge_complement.sv
// Sorted interval merge / complement: top level.
// Merges start-sorted intervals into runs and emits runs or the gaps around them within the bounds.
// Depends on simc_pkg.
//
// Usage
//   Slave stream: s_axis_tdata carries interval_start (bits 63:0) and
//   interval_stop (bits 127:64); s_axis_tlast marks the final interval.
//   Master stream: m_axis_tdata carries result_start (63:0) and
//   result_stop (127:64); m_axis_tlast marks the final result of a list.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 output_mode, 1 earliest_time, 2 latest_time); write only when idle.
// Timing
//   Each accepted interval is evaluated against the open run in the cycle it
//   is taken; its zero, one or two results enter a four-entry result queue
//   and are registered there before they reach the master side.
//   One interval per cycle is taken while the queue has room for two
//   results; two-result items drain at one result per cycle while m_axis_tready
//   is high, so the sustained rate is set by the single-result output port.
// Reset and stall
//   Reset empties the queue, closes the run and loads the register defaults.
//   When the receiver stalls the queue fills and s_axis_tready drops once
//   fewer than two entries are free.
module sorted_interval_merge_complement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [63:0] interval_start, [127:64] interval_stop
  input  logic [2*simc_pkg::TimeW-1:0]  s_axis_tdata,
  // final_interval
  input  logic                          s_axis_tlast,
  // Master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] result_start, [127:64] result_stop
  output logic [2*simc_pkg::TimeW-1:0]  m_axis_tdata,
  // result_last
  output logic                          m_axis_tlast,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [simc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [simc_pkg::TimeW-1:0]    cfg_data_i
);

  localparam int unsigned W = simc_pkg::TimeW;

  // Configuration registers
  simc_pkg::out_mode_e mode_q;
  logic signed [W-1:0] earliest_q;
  logic signed [W-1:0] latest_q;

  // Open run state
  logic signed [W-1:0] run_begin_q, run_begin_d;
  logic signed [W-1:0] run_end_q, run_end_d;
  logic                run_open_q, run_open_d;

  // Result queue
  simc_pkg::result_t                 queue_q [simc_pkg::QueueDepth];
  logic [simc_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [simc_pkg::QueueCntW-1:0]    count_q, count_d;

  logic                in_xfer, out_xfer;
  logic signed [W-1:0] in_start, in_stop;
  logic                gaps, gap_seen, new_run;
  logic                res0_vld, res1_vld;
  simc_pkg::result_t   res0, res1, wr_a, wr_b;
  logic                wr_a_en, wr_b_en;
  logic [1:0]          push_n;

  assign in_start = s_axis_tdata[W-1:0];
  assign in_stop  = s_axis_tdata[2*W-1:W];

  assign s_axis_tready = (count_q <= simc_pkg::QueueCntW'(simc_pkg::QueueDepth - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count_q != '0);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= simc_pkg::ModeMerge;
      earliest_q <= {1'b1, {(W-2){1'b0}}, 1'b1};
      latest_q   <= {1'b0, {(W-2){1'b1}}, 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        simc_pkg::CfgOutputMode:   mode_q     <= simc_pkg::out_mode_e'(cfg_data_i[0]);
        simc_pkg::CfgEarliestTime: earliest_q <= cfg_data_i;
        simc_pkg::CfgLatestTime:   latest_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Evaluate the incoming interval against the open run
  always_comb begin
    gaps     = (mode_q == simc_pkg::ModeComplement);
    gap_seen = run_open_q && (in_start > run_end_q);
    new_run  = !run_open_q || gap_seen;

    // First result: opening gap, or on a gap either that gap or the run it closes
    res0_vld   = (!run_open_q && gaps) || gap_seen;
    res0.last  = 1'b0;
    if (!run_open_q) begin
      res0.start = earliest_q;
      res0.stop  = in_start;
    end else if (gaps) begin
      res0.start = run_end_q;
      res0.stop  = in_start;
    end else begin
      res0.start = run_begin_q;
      res0.stop  = run_end_q;
    end

    // Run update
    if (new_run) begin
      run_begin_d = in_start;
      run_end_d   = in_stop;
    end else begin
      run_begin_d = run_begin_q;
      run_end_d   = (in_stop > run_end_q) ? in_stop : run_end_q;
    end
    run_open_d = !s_axis_tlast;

    // Second result: closing the list
    res1_vld  = s_axis_tlast;
    res1.last = 1'b1;
    if (gaps) begin
      res1.start = run_end_d;
      res1.stop  = latest_q;
    end else begin
      res1.start = run_begin_d;
      res1.stop  = run_end_d;
    end

    // Queue write slots
    wr_a    = res0_vld ? res0 : res1;
    wr_b    = res1;
    wr_a_en = in_xfer && (res0_vld || res1_vld);
    wr_b_en = in_xfer && res0_vld && res1_vld;
    push_n  = {1'b0, wr_a_en} + {1'b0, wr_b_en};

    count_d = count_q + simc_pkg::QueueCntW'(push_n) - simc_pkg::QueueCntW'(out_xfer);
  end

  // Run state and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_begin_q <= '0;
      run_end_q   <= '0;
      run_open_q  <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
    end else begin
      if (in_xfer) begin
        run_begin_q <= run_begin_d;
        run_end_q   <= run_end_d;
        run_open_q  <= run_open_d;
      end
      wr_ptr_q <= wr_ptr_q + simc_pkg::QueuePtrW'(push_n);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_a_en) begin
      queue_q[wr_ptr_q] <= wr_a;
    end
    if (wr_b_en) begin
      queue_q[wr_ptr_q + 1'b1] <= wr_b;
    end
  end

  assign m_axis_tdata = {queue_q[rd_ptr_q].stop, queue_q[rd_ptr_q].start};
  assign m_axis_tlast = queue_q[rd_ptr_q].last;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= simc_pkg::QueueCntW'(simc_pkg::QueueDepth))
    else $error("result queue overfilled");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast |=> !run_open_q)
    else $error("run still open after final interval");

  a_item_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !s_axis_tlast |=> run_open_q)
    else $error("no run open after interval transfer");

  a_final_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast |=> m_axis_tvalid)
    else $error("final interval produced no result");

endmodule

FILE: test/sorted_interval_merge_complement_test.sv
// Self-checking testbench for sorted_interval_merge_complement: streams interval lists,
// predicts merged runs or complement gaps and checks every result transfer in order.
// Depends on simc_pkg and the sorted_interval_merge_complement RTL.
module sorted_interval_merge_complement_test;

  localparam int TimeW         = simc_pkg::TimeW;
  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 300;
  localparam int TimeoutCycles = 200000;
  localparam int MaxReports    = 10;

  localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};
  localparam logic signed [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};

  // One interval waiting to be offered on the slave side
  typedef struct {
    logic signed [TimeW-1:0] start;
    logic signed [TimeW-1:0] stop;
    logic                    fin;
  } interval_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*TimeW-1:0]     s_axis_tdata  = '0;   // [63:0] interval_start, [127:64] interval_stop
  logic                   s_axis_tlast  = 1'b0; // final_interval
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*TimeW-1:0]     m_axis_tdata;         // [63:0] result_start, [127:64] result_stop
  logic                   m_axis_tlast;         // result_last
  logic                   cfg_we_i      = 1'b0;
  logic [simc_pkg::CfgIdxW-1:0] cfg_idx_i = simc_pkg::CfgOutputMode;
  logic [TimeW-1:0]       cfg_data_i    = '0;

  sorted_interval_merge_complement i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    #(ClkPeriod/2) clk_i = 1'b1;
    #(ClkPeriod/2) clk_i = 1'b0;
  end

  // Register copies and open-run state of the predictor
  simc_pkg::out_mode_e     mode_set     = simc_pkg::ModeMerge;
  logic signed [TimeW-1:0] earliest_set = TimeMin + 1;
  logic signed [TimeW-1:0] latest_set   = TimeMax - 1;
  logic signed [TimeW-1:0] open_from    = '0;
  logic signed [TimeW-1:0] open_to      = '0;
  logic                    span_open    = 1'b0;

  interval_t          intervals_to_send[$];
  simc_pkg::result_t  due_spans[$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_left       = 0;
  logic hold_start    = 1'b0;

  int intervals_taken = 0;
  int results_checked = 0;
  int lists_closed    = 0;
  int mismatches      = 0;
  int settings_used   = 1;

  function automatic void owe_span(logic signed [TimeW-1:0] span_start,
                                   logic signed [TimeW-1:0] span_stop, logic fin);
    simc_pkg::result_t r;
    r.start = span_start;
    r.stop  = span_stop;
    r.last  = fin;
    due_spans.push_back(r);
  endfunction

  // Fold one interval into the open run and queue the runs or gaps it closes
  function automatic void fold_interval(logic signed [TimeW-1:0] ival_start,
                                        logic signed [TimeW-1:0] ival_stop, logic fin);
    if (!span_open) begin
      if (mode_set == simc_pkg::ModeComplement) owe_span(earliest_set, ival_start, 1'b0);
      open_from = ival_start;
      open_to   = ival_stop;
      span_open = 1'b1;
    end else if (ival_start <= open_to) begin
      if (ival_stop > open_to) open_to = ival_stop;
    end else begin
      if (mode_set == simc_pkg::ModeComplement) owe_span(open_to, ival_start, 1'b0);
      else owe_span(open_from, open_to, 1'b0);
      open_from = ival_start;
      open_to   = ival_stop;
    end
    if (fin) begin
      if (mode_set == simc_pkg::ModeComplement) owe_span(open_to, latest_set, 1'b1);
      else owe_span(open_from, open_to, 1'b1);
      span_open = 1'b0;
    end
  endfunction

  // Slave-side driver: offers queued intervals, predicts on each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    interval_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        fold_interval(s_axis_tdata[TimeW-1:0], s_axis_tdata[2*TimeW-1:TimeW], s_axis_tlast);
        intervals_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (intervals_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = intervals_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.stop, nxt.start};
          s_axis_tlast  <= nxt.fin;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Master-side ready with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && !hold_start && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: each result transfer against the oldest owed span
  always @(posedge clk_i) begin
    simc_pkg::result_t got;
    simc_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      results_checked++;
      if (got.last) lists_closed++;
      if (due_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: start %0d stop %0d last %0b",
                   got.start, got.stop, got.last);
      end else begin
        want = due_spans.pop_front();
        if (got.start !== want.start || got.stop !== want.stop || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d mismatch: expected %0d..%0d last %0b, got %0d..%0d last %0b",
                     results_checked, want.start, want.stop, want.last,
                     got.start, got.stop, got.last);
        end
      end
    end
  end

  function automatic void send_interval(logic signed [TimeW-1:0] ival_start,
                                        logic signed [TimeW-1:0] ival_stop, logic fin);
    interval_t it;
    it.start = ival_start;
    it.stop  = ival_stop;
    it.fin   = fin;
    intervals_to_send.push_back(it);
  endfunction

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return TimeMin;
      1:       return TimeMax;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write one register; the block is idle whenever this is called
  task automatic write_register(input simc_pkg::cfg_idx_e idx, input logic [TimeW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      simc_pkg::CfgOutputMode:   mode_set = simc_pkg::out_mode_e'(value[0]);
      simc_pkg::CfgEarliestTime: earliest_set = value;
      simc_pkg::CfgLatestTime:   latest_set = value;
      default: ;
    endcase
  endtask

  // Mostly sorted lists with random content, some noise and unterminated lists
  task automatic queue_random_lists(input int n_items);
    int                      left;
    int                      len;
    logic signed [TimeW-1:0] t;
    logic signed [TimeW-1:0] stop;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 6);
        if (len > left) len = left;
        case ($urandom_range(0, 2))
          0:       t = {$urandom, $urandom};
          1:       t = $signed(64'($urandom_range(0, 2000))) - 1000;
          default: t = TimeMax - $urandom_range(0, 100);
        endcase
        for (int i = 0; i < len; i++) begin
          t = t + $urandom_range(0, 20);
          if ($urandom_range(0, 9) == 0) stop = t - $urandom_range(1, 10);
          else stop = t + $urandom_range(0, 25);
          send_interval(t, stop, i == len - 1);
        end
        left -= len;
      end else begin
        send_interval({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  // Everything accepted, every owed span seen, then let the block settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (intervals_to_send.size() != 0 || s_axis_tvalid || due_spans.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    int idle_pcts[5]  = '{0, 54, 0, 30, 0};
    int stall_pcts[5] = '{0, 0, 54, 30, 0};
    int phase_items[5] = '{100, 100, 100, 100, 40};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, merge mode: extremes, containment, touching, gap, unsorted, reversed
    send_interval(TimeMin, TimeMax, 1'b1);
    send_interval(TimeMax, TimeMin, 1'b1);
    send_interval(0, 10, 1'b0);
    send_interval(5, 8, 1'b0);
    send_interval(10, 20, 1'b0);
    send_interval(21, 30, 1'b0);
    send_interval(15, 12, 1'b0);
    send_interval(40, 35, 1'b1);
    wait_drained();

    // Complement mode with the reset bounds
    write_register(simc_pkg::CfgOutputMode, 64'(simc_pkg::ModeComplement));
    send_interval(-5, 5, 1'b0);
    send_interval(3, 9, 1'b0);
    send_interval(20, 25, 1'b1);
    wait_drained();

    // Bounds on the wrong side of the runs
    write_register(simc_pkg::CfgEarliestTime, TimeMax);
    write_register(simc_pkg::CfgLatestTime, TimeMin);
    send_interval(0, 1, 1'b1);
    wait_drained();

    // Mode changes in the middle of a list, both ways
    write_register(simc_pkg::CfgEarliestTime, TimeMin);
    write_register(simc_pkg::CfgLatestTime, TimeMax);
    send_interval(100, 200, 1'b0);
    wait_drained();
    write_register(simc_pkg::CfgOutputMode, 64'(simc_pkg::ModeMerge));
    send_interval(300, 400, 1'b1);
    send_interval(0, 5, 1'b0);
    wait_drained();
    write_register(simc_pkg::CfgOutputMode, 64'(simc_pkg::ModeComplement));
    send_interval(10, 20, 1'b1);
    wait_drained();
    settings_used += 5;

    // Random phases with varied idling; the last one holds the receiver off
    for (int ph = 0; ph < 5; ph++) begin
      sender_idle_pct = idle_pcts[ph];
      stall_pct       = stall_pcts[ph];
      write_register(simc_pkg::CfgOutputMode, 64'($urandom_range(0, 1)));
      write_register(simc_pkg::CfgEarliestTime, pick_time());
      write_register(simc_pkg::CfgLatestTime, pick_time());
      settings_used++;
      if (ph == 4) begin
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      queue_random_lists(phase_items[ph]);
      wait_drained();
    end

    $display("summary: %0d intervals over %0d register settings, %0d results checked",
             intervals_taken, settings_used, results_checked);
    $display("summary: %0d lists closed, %0d mismatches", lists_closed, mismatches);
    if (mismatches == 0 && due_spans.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("tb: failure");
    $finish;
  end

endmodule
